/* rtl/fsha_pkg.sv */
// ----------------------------------------------------------------------------
// fsha_pkg
// Shared types, codes and constants of the fit-strategy heap allocator.
// ----------------------------------------------------------------------------
package fsha_pkg;

  localparam int FW             = 21;
  localparam int MAX_SEGMENTS   = 256;
  localparam int MAX_HEAP_BYTES = 1048576;
  localparam int PAGE_SHIFT     = 12;
  localparam int HEADER_BYTES   = 24;

  localparam logic [FW:0] HDR      = (FW+1)'(HEADER_BYTES);
  localparam logic [FW:0] PAGE_M1  = (FW+1)'((1 << PAGE_SHIFT) - 1);
  localparam logic [FW:0] HEAP_MAX = (FW+1)'(MAX_HEAP_BYTES);

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] STRAT_BEST  = 2'd0;
  localparam logic [1:0] STRAT_WORST = 2'd1;
  localparam logic [1:0] STRAT_FIRST = 2'd2;
  localparam logic [1:0] STRAT_NEXT  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_INIT = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_FIT   = 3'd3;
  localparam logic [2:0] ST_BAD_FREE = 3'd4;

  localparam logic REG_HEAP_SIZE = 1'b0;

  typedef struct packed {
    logic [FW-1:0] off;
    logic [FW-1:0] size;
    logic          free;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_INIT,
    DP_FIND_LS,
    DP_SCAN,
    DP_WR_EXACT,
    DP_SHIFT_INIT,
    DP_SHIFT_WR,
    DP_SPLIT1,
    DP_SPLIT2,
    DP_FREE_FIND,
    DP_MERGE_STEP,
    DP_MERGE_END
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LS_RD,
    S_LS_EV,
    S_SC_RD,
    S_SC_EV,
    S_DECIDE,
    S_SH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_SP_WR1,
    S_SP_WR2,
    S_FR_RD,
    S_FR_EV,
    S_MG_RD,
    S_MG_EV,
    S_MG_END,
    S_OK
  } st_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_en;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] strat;
    logic       ready;
    logic       lsv;
    logic       init_ok;
    logic       fa_zero;
    logic       ls_done;
    logic       scan_done;
    logic       found;
    logic       split_need;
    logic       exact;
    logic       full;
    logic       shift_more;
    logic       fr_hit;
    logic       last;
  } sts_t;

endpackage

/* rtl/fsha_ram.sv */
// ----------------------------------------------------------------------------
// fsha_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fsha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fsha_dp.sv */
// ----------------------------------------------------------------------------
// fsha_dp
// Datapath: segment table, scan index, chosen segment, merge holder, result.
// ----------------------------------------------------------------------------
module fsha_dp #(
  parameter int MAX_SEGMENTS = fsha_pkg::MAX_SEGMENTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fsha_pkg::cmd_t            cmd,
  output fsha_pkg::sts_t            sts,
  input  logic [1:0]                in_opcode,
  input  logic [fsha_pkg::FW-1:0]   in_request_size,
  input  logic [1:0]                in_strategy,
  input  logic [fsha_pkg::FW-1:0]   in_free_address,
  input  logic [fsha_pkg::FW-1:0]   heap_size,
  output logic                      out_strobe,
  output logic [2:0]                out_status,
  output logic [fsha_pkg::FW-1:0]   out_address
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam int FW = fsha_pkg::FW;

  logic [1:0]      op_r, strat_r;
  logic [FW-1:0]   req_r, fa_r;
  logic            ready_r, lsv_r, found_r, hold_v_r;
  logic [FW-1:0]   lso_r, addr_r;
  logic [CW-1:0]   cnt_r;
  logic [IW-1:0]   i_r, ch_idx_r, w_r;
  fsha_pkg::seg_t  ch_r, hold_r;
  logic            out_strobe_r;
  logic [2:0]      out_status_r;
  logic [FW-1:0]   out_address_r;

  fsha_pkg::seg_t  q, e, wdata;
  logic            we;
  logic [IW-1:0]   waddr;
  logic [FW:0]     rsum, rounded;
  logic            cand, better, i_last, ls_hit, fr_hit, merge_join;
  logic [FW:0]     split_off, split_size;

  fsha_ram #(.WIDTH(fsha_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (i_r),
    .rdata (q)
  );

  // page round-up by mask
  assign rsum    = {1'b0, heap_size} + fsha_pkg::PAGE_M1;
  assign rounded = rsum & ~fsha_pkg::PAGE_M1;

  assign i_last = ({1'b0, i_r} + CW'(1)) >= cnt_r;
  assign cand   = q.free && (q.size >= req_r);
  assign ls_hit = q.off == lso_r;
  assign fr_hit = ({1'b0, q.off} + fsha_pkg::HDR) == {1'b0, fa_r};

  always_comb begin
    case (strat_r)
      fsha_pkg::STRAT_BEST:  better = !found_r || (ch_r.size > q.size);
      fsha_pkg::STRAT_WORST: better = !found_r || (ch_r.size < q.size);
      default:               better = 1'b1;
    endcase
  end

  // the segment being freed counts as free during the merge pass
  always_comb begin
    e      = q;
    e.free = q.free || (i_r == ch_idx_r);
  end
  assign merge_join = hold_r.free && e.free;

  assign split_off  = {1'b0, ch_r.off} + fsha_pkg::HDR + {1'b0, req_r};
  assign split_size = {1'b0, ch_r.size} - {1'b0, req_r} - fsha_pkg::HDR;

  always_comb begin
    sts.op         = op_r;
    sts.strat      = strat_r;
    sts.ready      = ready_r;
    sts.lsv        = lsv_r;
    sts.init_ok    = (heap_size != '0) && (rounded <= fsha_pkg::HEAP_MAX) &&
                     (rounded >= fsha_pkg::HDR);
    sts.fa_zero    = fa_r == '0;
    sts.ls_done    = ls_hit || i_last;
    sts.scan_done  = i_last || (cand && strat_r[1]);
    sts.found      = found_r;
    sts.split_need = {1'b0, ch_r.size} > ({1'b0, req_r} + fsha_pkg::HDR);
    sts.exact      = ch_r.size == req_r;
    sts.full       = cnt_r >= CW'(MAX_SEGMENTS);
    sts.shift_more = i_r > ch_idx_r;
    sts.fr_hit     = fr_hit;
    sts.last       = i_last;
  end

  always_comb begin
    we    = 1'b0;
    waddr = ch_idx_r;
    wdata = hold_r;
    case (cmd.op)
      fsha_pkg::DP_INIT: begin
        we    = sts.init_ok;
        waddr = '0;
        wdata = '{off: '0, size: FW'(rounded - fsha_pkg::HDR), free: 1'b1};
      end
      fsha_pkg::DP_WR_EXACT: begin
        we    = 1'b1;
        wdata = '{off: ch_r.off, size: ch_r.size, free: 1'b0};
      end
      fsha_pkg::DP_SHIFT_WR: begin
        we    = 1'b1;
        waddr = i_r + IW'(1);
        wdata = q;
      end
      fsha_pkg::DP_SPLIT1: begin
        we    = 1'b1;
        waddr = ch_idx_r + IW'(1);
        wdata = '{off: FW'(split_off), size: FW'(split_size), free: 1'b1};
      end
      fsha_pkg::DP_SPLIT2: begin
        we    = 1'b1;
        wdata = '{off: ch_r.off, size: req_r, free: 1'b0};
      end
      fsha_pkg::DP_MERGE_STEP: begin
        we    = hold_v_r && !merge_join;
        waddr = w_r;
      end
      fsha_pkg::DP_MERGE_END: begin
        we    = 1'b1;
        waddr = w_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r      <= 1'b0;
      lsv_r        <= 1'b0;
      lso_r        <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.res_en;
      case (cmd.op)
        fsha_pkg::DP_INIT: begin
          if (sts.init_ok) begin
            cnt_r   <= CW'(1);
            lsv_r   <= 1'b0;
            lso_r   <= '0;
            ready_r <= 1'b1;
          end
        end
        fsha_pkg::DP_WR_EXACT: begin
          lso_r <= ch_r.off;
          lsv_r <= 1'b1;
        end
        fsha_pkg::DP_SPLIT2: begin
          cnt_r <= cnt_r + CW'(1);
          lso_r <= ch_r.off;
          lsv_r <= 1'b1;
        end
        fsha_pkg::DP_MERGE_END: begin
          cnt_r <= {1'b0, w_r} + CW'(1);
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      out_status_r  <= cmd.res_status;
      out_address_r <= addr_r;
    end
    case (cmd.op)
      fsha_pkg::DP_LATCH: begin
        op_r    <= in_opcode;
        req_r   <= in_request_size;
        strat_r <= in_strategy;
        fa_r    <= in_free_address;
        i_r     <= '0;
        found_r <= 1'b0;
        addr_r  <= '0;
      end
      fsha_pkg::DP_FIND_LS: begin
        if (ls_hit) begin
          i_r <= i_last ? '0 : i_r + IW'(1);
        end else if (i_last) begin
          i_r <= '0;
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
      fsha_pkg::DP_SCAN: begin
        if (cand && better) begin
          ch_r     <= q;
          ch_idx_r <= i_r;
          found_r  <= 1'b1;
        end
        i_r <= i_r + IW'(1);
      end
      fsha_pkg::DP_WR_EXACT: begin
        addr_r <= FW'({1'b0, ch_r.off} + fsha_pkg::HDR);
      end
      fsha_pkg::DP_SHIFT_INIT: begin
        i_r <= IW'(cnt_r - CW'(1));
      end
      fsha_pkg::DP_SHIFT_WR: begin
        i_r <= i_r - IW'(1);
      end
      fsha_pkg::DP_SPLIT2: begin
        addr_r <= FW'({1'b0, ch_r.off} + fsha_pkg::HDR);
      end
      fsha_pkg::DP_FREE_FIND: begin
        if (fr_hit) begin
          ch_idx_r <= i_r;
          i_r      <= '0;
          w_r      <= '0;
          hold_v_r <= 1'b0;
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
      fsha_pkg::DP_MERGE_STEP: begin
        if (!hold_v_r) begin
          hold_r   <= e;
          hold_v_r <= 1'b1;
        end else if (merge_join) begin
          hold_r.size <= FW'({1'b0, hold_r.size} + fsha_pkg::HDR + {1'b0, e.size});
        end else begin
          hold_r <= e;
          w_r    <= w_r + IW'(1);
        end
        i_r <= i_r + IW'(1);
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  assign out_strobe  = out_strobe_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count above table depth");
  a_ready_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (cnt_r != '0))
    else $error("initialized heap with empty table");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

/* rtl/fsha_ctrl.sv */
// ----------------------------------------------------------------------------
// fsha_ctrl
// Controller: sequences scans, shifts and merges through datapath commands.
// ----------------------------------------------------------------------------
module fsha_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fsha_pkg::sts_t sts,
  output fsha_pkg::cmd_t cmd,
  output logic           busy
);

  fsha_pkg::st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsha_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsha_pkg::S_IDLE: begin
        if (start) state_nxt = fsha_pkg::S_DISPATCH;
      end
      fsha_pkg::S_DISPATCH: begin
        state_nxt = fsha_pkg::S_IDLE;
        if (sts.op == fsha_pkg::OP_ALLOC && sts.ready) begin
          if (sts.strat == fsha_pkg::STRAT_NEXT && sts.lsv) begin
            state_nxt = fsha_pkg::S_LS_RD;
          end else begin
            state_nxt = fsha_pkg::S_SC_RD;
          end
        end else if (sts.op == fsha_pkg::OP_FREE && sts.ready && !sts.fa_zero) begin
          state_nxt = fsha_pkg::S_FR_RD;
        end
      end
      fsha_pkg::S_LS_RD: state_nxt = fsha_pkg::S_LS_EV;
      fsha_pkg::S_LS_EV: begin
        state_nxt = sts.ls_done ? fsha_pkg::S_SC_RD : fsha_pkg::S_LS_RD;
      end
      fsha_pkg::S_SC_RD: state_nxt = fsha_pkg::S_SC_EV;
      fsha_pkg::S_SC_EV: begin
        state_nxt = sts.scan_done ? fsha_pkg::S_DECIDE : fsha_pkg::S_SC_RD;
      end
      fsha_pkg::S_DECIDE: begin
        if (!sts.found) begin
          state_nxt = fsha_pkg::S_IDLE;
        end else if (sts.split_need) begin
          state_nxt = sts.full ? fsha_pkg::S_IDLE : fsha_pkg::S_SH_CHK;
        end else if (sts.exact) begin
          state_nxt = fsha_pkg::S_OK;
        end else begin
          state_nxt = fsha_pkg::S_IDLE;
        end
      end
      fsha_pkg::S_SH_CHK: begin
        state_nxt = sts.shift_more ? fsha_pkg::S_SH_RD : fsha_pkg::S_SP_WR1;
      end
      fsha_pkg::S_SH_RD:  state_nxt = fsha_pkg::S_SH_WR;
      fsha_pkg::S_SH_WR:  state_nxt = fsha_pkg::S_SH_CHK;
      fsha_pkg::S_SP_WR1: state_nxt = fsha_pkg::S_SP_WR2;
      fsha_pkg::S_SP_WR2: state_nxt = fsha_pkg::S_OK;
      fsha_pkg::S_FR_RD:  state_nxt = fsha_pkg::S_FR_EV;
      fsha_pkg::S_FR_EV: begin
        if (sts.fr_hit) begin
          state_nxt = fsha_pkg::S_MG_RD;
        end else if (sts.last) begin
          state_nxt = fsha_pkg::S_IDLE;
        end else begin
          state_nxt = fsha_pkg::S_FR_RD;
        end
      end
      fsha_pkg::S_MG_RD: state_nxt = fsha_pkg::S_MG_EV;
      fsha_pkg::S_MG_EV: begin
        state_nxt = sts.last ? fsha_pkg::S_MG_END : fsha_pkg::S_MG_RD;
      end
      fsha_pkg::S_MG_END: state_nxt = fsha_pkg::S_OK;
      fsha_pkg::S_OK:     state_nxt = fsha_pkg::S_IDLE;
      default:            state_nxt = fsha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '{op: fsha_pkg::DP_NOP, res_en: 1'b0, res_status: fsha_pkg::ST_OK};
    busy = state_r != fsha_pkg::S_IDLE;
    case (state_r)
      fsha_pkg::S_IDLE: begin
        if (start) cmd.op = fsha_pkg::DP_LATCH;
      end
      fsha_pkg::S_DISPATCH: begin
        case (sts.op)
          fsha_pkg::OP_INIT: begin
            cmd.op         = fsha_pkg::DP_INIT;
            cmd.res_en     = 1'b1;
            cmd.res_status = sts.init_ok ? fsha_pkg::ST_OK : fsha_pkg::ST_BAD_SIZE;
          end
          fsha_pkg::OP_ALLOC: begin
            if (!sts.ready) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = fsha_pkg::ST_NOT_INIT;
            end
          end
          fsha_pkg::OP_FREE: begin
            if (!sts.ready) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = fsha_pkg::ST_NOT_INIT;
            end else if (sts.fa_zero) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = fsha_pkg::ST_BAD_FREE;
            end
          end
          default: begin
            cmd.res_en = 1'b1;
          end
        endcase
      end
      fsha_pkg::S_LS_EV: cmd.op = fsha_pkg::DP_FIND_LS;
      fsha_pkg::S_SC_EV: cmd.op = fsha_pkg::DP_SCAN;
      fsha_pkg::S_DECIDE: begin
        if (sts.found && sts.split_need && !sts.full) begin
          cmd.op = fsha_pkg::DP_SHIFT_INIT;
        end else if (sts.found && !sts.split_need && sts.exact) begin
          cmd.op = fsha_pkg::DP_WR_EXACT;
        end else begin
          cmd.res_en     = 1'b1;
          cmd.res_status = fsha_pkg::ST_NO_FIT;
        end
      end
      fsha_pkg::S_SH_WR:  cmd.op = fsha_pkg::DP_SHIFT_WR;
      fsha_pkg::S_SP_WR1: cmd.op = fsha_pkg::DP_SPLIT1;
      fsha_pkg::S_SP_WR2: cmd.op = fsha_pkg::DP_SPLIT2;
      fsha_pkg::S_FR_EV: begin
        cmd.op = fsha_pkg::DP_FREE_FIND;
        if (!sts.fr_hit && sts.last) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = fsha_pkg::ST_BAD_FREE;
        end
      end
      fsha_pkg::S_MG_EV:  cmd.op = fsha_pkg::DP_MERGE_STEP;
      fsha_pkg::S_MG_END: cmd.op = fsha_pkg::DP_MERGE_END;
      fsha_pkg::S_OK:     cmd.res_en = 1'b1;
      default:            cmd.op = fsha_pkg::DP_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsha_pkg::S_SH_WR) |-> sts.shift_more)
    else $error("shift past the chosen segment");
  a_res_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_en |=> (state_r == fsha_pkg::S_IDLE))
    else $error("sequencer not idle after result");
`endif

endmodule

/* rtl/fit_strategy_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// fit_strategy_heap_allocator_core
// Heap allocator over an address-ordered segment table with best, worst,
// first and next fit, segment split and free-run merging.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     start / busy               in_opcode, in_request_size,
//                                       in_strategy, in_free_address
//  result    out_strobe (one cycle)     out_status, out_address
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata (heap_size)
//
//  init, no-op and early errors: result set in the dispatch state, strobe registered
//  alloc: scans the table entries (after a next-fit lookup of the last allocated
//  segment) and shifts entries up on a split; free: searches the entries, then
//  merges free runs in one pass; each step reads the one registered table port
//  rst_n is synchronous; the table holds no valid state until an init
//  busy stays high from acceptance to the result; results cannot be stalled
// ----------------------------------------------------------------------------
module fit_strategy_heap_allocator_core #(
  parameter int MAX_SEGMENTS = fsha_pkg::MAX_SEGMENTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [fsha_pkg::FW-1:0] in_request_size,
  input  logic [1:0]              in_strategy,
  input  logic [fsha_pkg::FW-1:0] in_free_address,
  output logic                    out_strobe,
  output logic [2:0]              out_status,
  output logic [fsha_pkg::FW-1:0] out_address,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [fsha_pkg::FW-1:0] heap_size_r;
  fsha_pkg::cmd_t          cmd;
  fsha_pkg::sts_t          sts;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= '0;
    end else if (cfg_wr && paddr[2] == fsha_pkg::REG_HEAP_SIZE) begin
      heap_size_r <= pwdata[fsha_pkg::FW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fsha_pkg::REG_HEAP_SIZE) begin
      prdata = {{(32-fsha_pkg::FW){1'b0}}, heap_size_r};
    end
  end

  fsha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fsha_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_strategy     (in_strategy),
    .in_free_address (in_free_address),
    .heap_size       (heap_size_r),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_address     (out_address)
  );

endmodule
